FILE: sv/least_loaded_job_dispatcher_assert.svh
// Assertion macros for the least-loaded job dispatcher.
// Used by the top level only; needs no other file.
`ifndef LEAST_LOADED_JOB_DISPATCHER_ASSERT_SVH
`define LEAST_LOADED_JOB_DISPATCHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LLJ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LLJ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/llj_pkg.sv
// Shared types and constants for the least-loaded job dispatcher.
// No dependencies; used by llj_cdiv and least_loaded_job_dispatcher.
`timescale 1ns / 1ps
`default_nettype none

package llj_pkg;

    localparam int MAX_WORKERS = 16;
    localparam int W_IDX       = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

    localparam int LOAD_W  = 16;
    localparam int COUNT_W = 5;
    localparam int HHMM_W  = 12;
    localparam int JOB_W   = 10;
    localparam int WNUM_W  = 5;

    // Constant divider sizes: dividend up to 17 bits, divisor 100, 60 or 24.
    // The quotient is (dividend * reciprocal) >> RCP_SHIFT, where each reciprocal is
    // ceil(2**24 / divisor); the rounding error is small enough to be exact below 2**17.
    localparam int DIV_W     = 17;
    localparam int REM_W     = 7;
    localparam int RCP_W     = 20;
    localparam int RCP_SHIFT = 24;

    localparam logic [REM_W-1:0] DIV_HHMM = 7'd100;
    localparam logic [REM_W-1:0] DIV_MIN  = 7'd60;
    localparam logic [REM_W-1:0] DIV_DAY  = 7'd24;

    localparam logic [RCP_W-1:0] RCP_HHMM = 20'd167773;
    localparam logic [RCP_W-1:0] RCP_MIN  = 20'd279621;
    localparam logic [RCP_W-1:0] RCP_DAY  = 20'd699051;

    localparam logic [COUNT_W-1:0] WORKER_COUNT_RESET = 5'd4;

    typedef struct packed {
        logic [HHMM_W-1:0] now_hhmm;
        logic [JOB_W-1:0]  job_minutes;
    } t_job_in;

    typedef struct packed {
        logic [WNUM_W-1:0] worker_number;
        logic [HHMM_W-1:0] finish_hhmm;
    } t_job_out;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [REM_W-1:0] divisor;
        logic [RCP_W-1:0] recip;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [REM_W-1:0] remainder;
    } t_div_rsp;

endpackage

`default_nettype wire

FILE: sv/llj_cdiv.sv
// Divider by a small constant: reciprocal multiply for the quotient, then the remainder.
// Depends on llj_pkg for widths and the request and response structs.
`timescale 1ns / 1ps
`default_nettype none

module llj_cdiv (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire llj_pkg::t_div_req i_req,
    output llj_pkg::t_div_rsp      o_rsp
);
    import llj_pkg::*;

    logic             r_mul, n_mul;
    logic             r_sub, n_sub;
    logic             r_done, n_done;
    logic [DIV_W-1:0] r_dvd, n_dvd;
    logic [REM_W-1:0] r_dvs, n_dvs;
    logic [RCP_W-1:0] r_rcp, n_rcp;
    logic [DIV_W-1:0] r_quo, n_quo;
    logic [REM_W-1:0] r_rem, n_rem;

    logic [DIV_W+RCP_W-1:0] product;
    logic [DIV_W+REM_W-1:0] back;
    logic [DIV_W-1:0]       left;

    assign product = r_dvd * r_rcp;
    assign back    = r_quo * r_dvs;
    assign left    = r_dvd - back[DIV_W-1:0];

    // The operand registers load first, the quotient is formed next and the remainder after it.
    always_comb begin
        n_mul  = 1'b0;
        n_sub  = r_mul;
        n_done = r_sub;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_rcp  = r_rcp;
        n_quo  = r_quo;
        n_rem  = r_rem;
        if (r_mul) begin
            n_quo = DIV_W'(product >> RCP_SHIFT);
        end
        if (r_sub) begin
            // The remainder is below the divisor, so it fits REM_W bits.
            n_rem = left[REM_W-1:0];
        end
        if (i_req.start && !r_mul && !r_sub) begin
            n_mul = 1'b1;
            n_dvd = i_req.dividend;
            n_dvs = i_req.divisor;
            n_rcp = i_req.recip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul  <= 1'b0;
            r_sub  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_mul  <= n_mul;
            r_sub  <= n_sub;
            r_done <= n_done;
        end
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rcp <= n_rcp;
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

FILE: sv/least_loaded_job_dispatcher.sv
// Top level of the least-loaded job dispatcher: sequencer, worker loads, output register.
// Depends on llj_pkg, llj_cdiv and least_loaded_job_dispatcher_assert.svh.
//
//   Channel   Direction  Handshake                 Payload
//   job in    input      i_in_valid / o_in_stall   i_in_data  (now_hhmm, job_minutes)
//   result    output     o_out_valid / i_out_stall o_out_data (worker_number, finish_hhmm)
//   config    input      i_cfg_we                  i_cfg_wdata (worker_count)
//
// After its transfer, a job first scans the worker loads up to the clamped worker count.
// The time arithmetic then runs on the shared constant divider as five divisions in turn,
// each passing through kick, reciprocal multiply, remainder and handoff, and a final step
// packs the result. Reset is synchronous and active low; it clears all worker loads and
// sets the worker count to 4. A stalled result holds in the output register, and the next
// job is taken as soon as the finished result is in that register.
`timescale 1ns / 1ps
`default_nettype none

module least_loaded_job_dispatcher (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [llj_pkg::COUNT_W-1:0]      i_cfg_wdata,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire llj_pkg::t_job_in                 i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output llj_pkg::t_job_out                     o_out_data
);
    import llj_pkg::*;

    `include "least_loaded_job_dispatcher_assert.svh"

    // The sequencer walks the scan, then the five divisions of the time arithmetic.
    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SCAN     = 8'b0000_0010,
        S_DIV_NOW  = 8'b0000_0100,
        S_DIV_LOAD = 8'b0000_1000,
        S_DIV_HOUR = 8'b0001_0000,
        S_DIV_JOB  = 8'b0010_0000,
        S_DIV_WRAP = 8'b0100_0000,
        S_FIN      = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    logic                r_kick, n_kick;
    logic [COUNT_W-1:0]  r_worker_count;
    logic [LOAD_W-1:0]   r_load [MAX_WORKERS];

    logic [HHMM_W-1:0]   r_now, n_now;
    logic [JOB_W-1:0]    r_dur, n_dur;
    logic [W_IDX-1:0]    r_last, n_last;
    logic [W_IDX-1:0]    r_idx, n_idx;
    logic [W_IDX-1:0]    r_best, n_best;
    logic [LOAD_W-1:0]   r_best_load, n_best_load;
    logic [10:0]         r_hour, n_hour;
    logic [REM_W-1:0]    r_min, n_min;
    logic                r_out_valid, n_out_valid;
    t_job_out            r_out_data, n_out_data;

    t_div_req            div_req;
    t_div_rsp            div_rsp;

    logic [W_IDX-1:0]    cfg_last;
    logic                out_free;
    logic                load_we;
    logic [LOAD_W:0]     grown_wide;
    logic [LOAD_W-1:0]   grown;
    logic [HHMM_W-1:0]   finish;
    logic [WNUM_W-1:0]   worker_number;

    logic                in_take;
    logic                in_div;
    logic                at_fin;
    logic                time_ok;

    llj_cdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // A count of zero searches only worker 1; a count above the pool searches the whole pool.
    always_comb begin
        if (r_worker_count == '0) begin
            cfg_last = '0;
        end else if (32'(r_worker_count) > MAX_WORKERS) begin
            cfg_last = W_IDX'(MAX_WORKERS - 1);
        end else begin
            cfg_last = W_IDX'(32'(r_worker_count) - 32'd1);
        end
    end

    // The output register is free when empty or when its result transfers this cycle.
    assign out_free = !r_out_valid || !i_out_stall;
    assign load_we  = (r_state == S_FIN) && out_free;

    // New load of the chosen worker, saturating at the register maximum.
    assign grown_wide = (LOAD_W+1)'(r_best_load) + (LOAD_W+1)'(r_dur);
    assign grown      = grown_wide[LOAD_W] ? {LOAD_W{1'b1}} : grown_wide[LOAD_W-1:0];

    // At the end of the sequence r_hour holds the wrapped hour and r_min the minutes.
    assign finish        = HHMM_W'(r_hour) * HHMM_W'(DIV_HHMM) + HHMM_W'(r_min);
    assign worker_number = WNUM_W'(32'(r_best) + 32'd1);

    // Divider operands for the division that the current state starts.
    always_comb begin
        div_req.start    = r_kick;
        div_req.dividend = '0;
        div_req.divisor  = DIV_MIN;
        div_req.recip    = RCP_MIN;
        unique case (r_state)
            S_DIV_NOW: begin
                div_req.dividend = DIV_W'(r_now);
                div_req.divisor  = DIV_HHMM;
                div_req.recip    = RCP_HHMM;
            end
            S_DIV_LOAD: begin
                div_req.dividend = DIV_W'(r_min) + DIV_W'(r_best_load);
                div_req.divisor  = DIV_MIN;
                div_req.recip    = RCP_MIN;
            end
            S_DIV_HOUR: begin
                div_req.dividend = DIV_W'(r_hour);
                div_req.divisor  = DIV_DAY;
                div_req.recip    = RCP_DAY;
            end
            S_DIV_JOB: begin
                div_req.dividend = DIV_W'(r_min) + DIV_W'(r_dur);
                div_req.divisor  = DIV_MIN;
                div_req.recip    = RCP_MIN;
            end
            S_DIV_WRAP: begin
                div_req.dividend = DIV_W'(r_hour);
                div_req.divisor  = DIV_DAY;
                div_req.recip    = RCP_DAY;
            end
            S_IDLE, S_SCAN, S_FIN: begin
                div_req.start = 1'b0;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // Sequencer. Each division state waits for the divider's done pulse, takes the quotient,
    // the remainder or both as it needs, and kicks off the next division; the last one moves to S_FIN.
    always_comb begin
        n_state     = r_state;
        n_kick      = 1'b0;
        n_now       = r_now;
        n_dur       = r_dur;
        n_last      = r_last;
        n_idx       = r_idx;
        n_best      = r_best;
        n_best_load = r_best_load;
        n_hour      = r_hour;
        n_min       = r_min;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_now       = i_in_data.now_hhmm;
                    n_dur       = i_in_data.job_minutes;
                    n_last      = cfg_last;
                    n_best      = '0;
                    n_best_load = r_load[0];
                    n_idx       = W_IDX'(1);
                    if (cfg_last == '0) begin
                        n_state = S_DIV_NOW;
                        n_kick  = 1'b1;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Strictly smaller only, so the lowest index wins a tie.
                if (r_load[r_idx] < r_best_load) begin
                    n_best      = r_idx;
                    n_best_load = r_load[r_idx];
                end
                if (r_idx == r_last) begin
                    n_state = S_DIV_NOW;
                    n_kick  = 1'b1;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DIV_NOW: begin
                if (div_rsp.done) begin
                    n_hour  = div_rsp.quotient[10:0];
                    n_min   = div_rsp.remainder;
                    n_state = S_DIV_LOAD;
                    n_kick  = 1'b1;
                end
            end
            S_DIV_LOAD: begin
                if (div_rsp.done) begin
                    n_hour  = r_hour + div_rsp.quotient[10:0];
                    n_min   = div_rsp.remainder;
                    n_state = S_DIV_HOUR;
                    n_kick  = 1'b1;
                end
            end
            S_DIV_HOUR: begin
                if (div_rsp.done) begin
                    n_hour  = 11'(div_rsp.remainder);
                    n_state = S_DIV_JOB;
                    n_kick  = 1'b1;
                end
            end
            S_DIV_JOB: begin
                if (div_rsp.done) begin
                    n_hour  = r_hour + div_rsp.quotient[10:0];
                    n_min   = div_rsp.remainder;
                    n_state = S_DIV_WRAP;
                    n_kick  = 1'b1;
                end
            end
            S_DIV_WRAP: begin
                if (div_rsp.done) begin
                    n_hour  = 11'(div_rsp.remainder);
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid              = 1'b1;
                    n_out_data.worker_number = worker_number;
                    n_out_data.finish_hhmm   = finish;
                    n_state                  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_kick         <= 1'b0;
            r_out_valid    <= 1'b0;
            r_worker_count <= WORKER_COUNT_RESET;
        end else begin
            r_state     <= n_state;
            r_kick      <= n_kick;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_worker_count <= i_cfg_wdata;
            end
        end
        r_now       <= n_now;
        r_dur       <= n_dur;
        r_last      <= n_last;
        r_idx       <= n_idx;
        r_best      <= n_best;
        r_best_load <= n_best_load;
        r_hour      <= n_hour;
        r_min       <= n_min;
        r_out_data  <= n_out_data;
    end

    // Worker loads start at zero; the chosen worker's entry is updated as its result enters the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_WORKERS; k++) begin
                r_load[k] <= '0;
            end
        end else if (load_we) begin
            r_load[r_best] <= grown;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Conditions watched by the checks below.
    assign in_take = i_in_valid && !o_in_stall;
    assign in_div  = (r_state == S_DIV_NOW) || (r_state == S_DIV_LOAD) ||
                     (r_state == S_DIV_HOUR) || (r_state == S_DIV_JOB) ||
                     (r_state == S_DIV_WRAP);
    assign at_fin  = (r_state == S_FIN);
    assign time_ok = (r_hour < 11'd24) && (r_min < DIV_MIN);

    // A transfer on the job input must close the input.
    `LLJ_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, in_take, o_in_stall, "input left open")
    // The chosen worker is always inside the searched range.
    `LLJ_ASSERT_NOW(a_best_in_range, i_clk, i_rst_n, o_in_stall, r_best <= r_last, "bad best index")
    // The divider only reports back while the sequencer waits on a division.
    `LLJ_ASSERT_NOW(a_done_in_div, i_clk, i_rst_n, div_rsp.done, in_div, "stray divider done")
    // The finished time is a proper clock time before it is packed.
    `LLJ_ASSERT_NOW(a_time_valid, i_clk, i_rst_n, at_fin, time_ok, "finish time out of range")

endmodule

`default_nettype wire
